/* src/ami2d_pkg.sv */
// Package for the 2D agent motion integrator.
// Holds the number format, register indexes, reset values and the step microcode.
// No dependencies.
`default_nettype none

package ami2d_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned CFG_W  = 31;
  localparam int unsigned DIR_W  = 18;
  localparam int unsigned PC_W   = 5;

  localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [2*WORD_W-1:0] HALF_LSB = 64'd1 << (FRAC_W - 1);

  localparam logic [CFG_W-1:0] RST_TIME_STEP = 31'd6554;
  localparam logic [CFG_W-1:0] RST_SPEED_GAIN = 31'd65536;
  localparam logic [CFG_W-1:0] RST_INV_MASS = 31'd65536;
  localparam logic [CFG_W-1:0] RST_CRUISE = 31'd655360;
  localparam logic [CFG_W-1:0] RST_MIN_SPEED = 31'd327680;
  localparam logic [CFG_W-1:0] RST_MAX_SPEED = 31'd1310720;
  localparam logic [CFG_W-1:0] RST_WORLD_W = 31'd65536000;
  localparam logic [CFG_W-1:0] RST_WORLD_H = 31'd65536000;
  localparam logic signed [WORD_W-1:0] ONE = 32'sd65536;

  typedef enum logic [2:0] {
    REG_TIME_STEP  = 3'd0,
    REG_SPEED_GAIN = 3'd1,
    REG_INV_MASS   = 3'd2,
    REG_CRUISE     = 3'd3,
    REG_MIN_SPEED  = 3'd4,
    REG_MAX_SPEED  = 3'd5,
    REG_WORLD_W    = 3'd6,
    REG_WORLD_H    = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2
  } op_t;

  typedef enum logic [4:0] {
    SRC_CRUISE = 5'd0,
    SRC_CS     = 5'd1,
    SRC_GAIN   = 5'd2,
    SRC_SF     = 5'd3,
    SRC_SL     = 5'd4,
    SRC_EX     = 5'd5,
    SRC_EY     = 5'd6,
    SRC_DIRX   = 5'd7,
    SRC_DIRY   = 5'd8,
    SRC_ACCX   = 5'd9,
    SRC_ACCY   = 5'd10,
    SRC_HDT    = 5'd11,
    SRC_DT     = 5'd12,
    SRC_INVM   = 5'd13,
    SRC_POSX   = 5'd14,
    SRC_POSY   = 5'd15,
    SRC_VX     = 5'd16,
    SRC_VY     = 5'd17,
    SRC_T0     = 5'd18,
    SRC_T1     = 5'd19,
    SRC_FX     = 5'd20,
    SRC_FY     = 5'd21
  } src_t;

  typedef enum logic [3:0] {
    DST_T0   = 4'd0,
    DST_T1   = 4'd1,
    DST_FX   = 4'd2,
    DST_FY   = 4'd3,
    DST_VX   = 4'd4,
    DST_VY   = 4'd5,
    DST_POSX = 4'd6,
    DST_POSY = 4'd7,
    DST_ACCX = 4'd8,
    DST_ACCY = 4'd9
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t srca;
    src_t srcb;
    dst_t dst;
  } uop_t;

  localparam logic [PC_W-1:0] UCODE_LAST = 5'd26;

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = '{OP_SUB, SRC_CRUISE, SRC_CS,   DST_T0};
      5'd1:  u = '{OP_MUL, SRC_GAIN,   SRC_T0,   DST_T0};
      5'd2:  u = '{OP_ADD, SRC_SF,     SRC_T0,   DST_T0};
      5'd3:  u = '{OP_MUL, SRC_T0,     SRC_DIRX, DST_T1};
      5'd4:  u = '{OP_MUL, SRC_SL,     SRC_DIRY, DST_FX};
      5'd5:  u = '{OP_SUB, SRC_T1,     SRC_FX,   DST_FX};
      5'd6:  u = '{OP_MUL, SRC_T0,     SRC_DIRY, DST_T1};
      5'd7:  u = '{OP_MUL, SRC_SL,     SRC_DIRX, DST_FY};
      5'd8:  u = '{OP_ADD, SRC_T1,     SRC_FY,   DST_FY};
      5'd9:  u = '{OP_MUL, SRC_CS,     SRC_DIRX, DST_VX};
      5'd10: u = '{OP_MUL, SRC_ACCX,   SRC_HDT,  DST_T1};
      5'd11: u = '{OP_ADD, SRC_VX,     SRC_T1,   DST_VX};
      5'd12: u = '{OP_MUL, SRC_CS,     SRC_DIRY, DST_VY};
      5'd13: u = '{OP_MUL, SRC_ACCY,   SRC_HDT,  DST_T1};
      5'd14: u = '{OP_ADD, SRC_VY,     SRC_T1,   DST_VY};
      5'd15: u = '{OP_MUL, SRC_VX,     SRC_DT,   DST_T1};
      5'd16: u = '{OP_ADD, SRC_POSX,   SRC_T1,   DST_POSX};
      5'd17: u = '{OP_MUL, SRC_VY,     SRC_DT,   DST_T1};
      5'd18: u = '{OP_ADD, SRC_POSY,   SRC_T1,   DST_POSY};
      5'd19: u = '{OP_ADD, SRC_EX,     SRC_FX,   DST_T1};
      5'd20: u = '{OP_MUL, SRC_T1,     SRC_INVM, DST_ACCX};
      5'd21: u = '{OP_ADD, SRC_EY,     SRC_FY,   DST_T1};
      5'd22: u = '{OP_MUL, SRC_T1,     SRC_INVM, DST_ACCY};
      5'd23: u = '{OP_MUL, SRC_ACCX,   SRC_HDT,  DST_T1};
      5'd24: u = '{OP_ADD, SRC_VX,     SRC_T1,   DST_VX};
      5'd25: u = '{OP_MUL, SRC_ACCY,   SRC_HDT,  DST_T1};
      5'd26: u = '{OP_ADD, SRC_VY,     SRC_T1,   DST_VY};
      default: u = '{OP_ADD, SRC_T0, SRC_T0, DST_T0};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

/* src/agent_motion_integrator_2d_top.sv */
// Top level of the 2D agent motion integrator: sequencer, shared multiplier and adder,
// iterative square root, heading divider and torus wrap.
// Depends on ami2d_pkg.
//
// Usage: each input item (steering and external forces) advances the agent by one
// time step. The configuration channel (cfg_index, cfg_data) writes the eight
// registers and is always ready; write it only while the block is idle.
// in_ready is high only while the sequencer is idle; one item is worked on at a time.
// From acceptance to out_valid an item passes through 27 microcode steps, each an
// execute and a write-back state through the shared multiplier and saturating adder,
// then the squaring of the velocity, the square root, each heading component in the
// shared restoring divider and each position component for the wrap.
// A finished item waits in the output register; the next item is accepted meanwhile
// and only its last step waits for the receiver to take the earlier one.
// Synchronous reset restores the register defaults, puts the agent at the origin
// heading along x at cruise speed and clears any pending item.
`default_nettype none

module agent_motion_integrator_2d_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_steer_forward,
  input  wire logic signed [31:0] in_steer_lateral,
  input  wire logic signed [31:0] in_external_force_x,
  input  wire logic signed [31:0] in_external_force_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [30:0]             out_position_x,
  output logic [30:0]             out_position_y,
  output logic signed [17:0]      out_heading_x,
  output logic signed [17:0]      out_heading_y,
  output logic [30:0]             out_speed_out,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_EXEC = 12'b0000_0000_0010,
    S_WB   = 12'b0000_0000_0100,
    S_SQA  = 12'b0000_0000_1000,
    S_SQB  = 12'b0000_0001_0000,
    S_ROOT = 12'b0000_0010_0000,
    S_LEN  = 12'b0000_0100_0000,
    S_DIVI = 12'b0000_1000_0000,
    S_DIV  = 12'b0001_0000_0000,
    S_MODI = 12'b0010_0000_0000,
    S_MOD  = 12'b0100_0000_0000,
    S_DONE = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [30:0] time_step_r, speed_gain_r, inv_mass_r, cruise_r;
  logic [30:0] min_speed_r, max_speed_r, world_w_r, world_h_r;

  logic signed [31:0] pos_x_r, pos_y_r, dir_x_r, dir_y_r, cs_r, acc_x_r, acc_y_r;
  logic signed [31:0] sf_r, sl_r, ex_r, ey_r;
  logic signed [31:0] t0_r, t1_r, fx_r, fy_r, vx_r, vy_r;

  logic [4:0]  pc_r;
  logic [4:0]  cnt_r;
  logic        sel_r;
  logic        shift_r;
  logic        neg_r;
  logic [63:0] prod_r;
  logic [32:0] acc_r;
  logic [63:0] n_r, root_r, bit_r;
  logic [30:0] len_r;
  logic [32:0] rem_r;
  logic [16:0] q_r;
  logic [31:0] dvd_r;

  logic        out_valid_r;
  logic [30:0] out_px_r, out_py_r, out_spd_r;
  logic signed [17:0] out_hx_r, out_hy_r;

  ami2d_pkg::uop_t uop;
  logic signed [31:0] op_a, op_b, wb_res;
  logic [31:0] mul_a, mul_b, ax, ay, ax_s, ay_s;
  logic [63:0] prod, rnd, shr, rsum;
  logic [32:0] sum33, rem2, rem_sub, dvs;
  logic        rem_ge;
  logic [30:0] len_c, spd_c, wsize;
  logic [31:0] m_sel;
  logic [32:0] rem_init;
  logic [16:0] q_nxt;
  logic signed [31:0] dir_new, pos_new, pos_sel;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] sel_src(input ami2d_pkg::src_t s);
    logic signed [31:0] v;
    case (s)
      ami2d_pkg::SRC_CRUISE: v = {1'b0, cruise_r};
      ami2d_pkg::SRC_CS:     v = cs_r;
      ami2d_pkg::SRC_GAIN:   v = {1'b0, speed_gain_r};
      ami2d_pkg::SRC_SF:     v = sf_r;
      ami2d_pkg::SRC_SL:     v = sl_r;
      ami2d_pkg::SRC_EX:     v = ex_r;
      ami2d_pkg::SRC_EY:     v = ey_r;
      ami2d_pkg::SRC_DIRX:   v = dir_x_r;
      ami2d_pkg::SRC_DIRY:   v = dir_y_r;
      ami2d_pkg::SRC_ACCX:   v = acc_x_r;
      ami2d_pkg::SRC_ACCY:   v = acc_y_r;
      ami2d_pkg::SRC_HDT:    v = {2'b00, time_step_r[30:1]};
      ami2d_pkg::SRC_DT:     v = {1'b0, time_step_r};
      ami2d_pkg::SRC_INVM:   v = {1'b0, inv_mass_r};
      ami2d_pkg::SRC_POSX:   v = pos_x_r;
      ami2d_pkg::SRC_POSY:   v = pos_y_r;
      ami2d_pkg::SRC_VX:     v = vx_r;
      ami2d_pkg::SRC_VY:     v = vy_r;
      ami2d_pkg::SRC_T0:     v = t0_r;
      ami2d_pkg::SRC_T1:     v = t1_r;
      ami2d_pkg::SRC_FX:     v = fx_r;
      ami2d_pkg::SRC_FY:     v = fy_r;
      default:               v = '0;
    endcase
    return v;
  endfunction

  assign uop  = ami2d_pkg::ucode(pc_r);
  assign op_a = sel_src(uop.srca);
  assign op_b = sel_src(uop.srcb);

  assign ax   = mag32(vx_r);
  assign ay   = mag32(vy_r);
  assign ax_s = (ax[31] | ay[31]) ? (ax >> 1) : ax;
  assign ay_s = (ax[31] | ay[31]) ? (ay >> 1) : ay;

  always_comb begin
    case (state_r)
      S_SQA: begin
        mul_a = ax_s;
        mul_b = ax_s;
      end
      S_SQB: begin
        mul_a = ay_s;
        mul_b = ay_s;
      end
      default: begin
        mul_a = mag32(op_a);
        mul_b = mag32(op_b);
      end
    endcase
  end

  assign prod  = 64'(mul_a) * 64'(mul_b);
  assign sum33 = (uop.op == ami2d_pkg::OP_SUB) ? ({op_a[31], op_a} - {op_b[31], op_b})
                                               : ({op_a[31], op_a} + {op_b[31], op_b});

  always_comb begin
    rnd = prod_r + ami2d_pkg::HALF_LSB;
    shr = rnd >> ami2d_pkg::FRAC_W;
    if (uop.op == ami2d_pkg::OP_MUL) begin
      if (shr > 64'(ami2d_pkg::WMAX)) begin
        wb_res = neg_r ? ami2d_pkg::WMIN : ami2d_pkg::WMAX;
      end else begin
        wb_res = neg_r ? 32'(-shr[31:0]) : shr[31:0];
      end
    end else if (acc_r[32] != acc_r[31]) begin
      wb_res = acc_r[32] ? ami2d_pkg::WMIN : ami2d_pkg::WMAX;
    end else begin
      wb_res = acc_r[31:0];
    end
  end

  assign rsum = root_r + bit_r;

  always_comb begin
    if (shift_r) begin
      len_c = (root_r > 64'(ami2d_pkg::WMAX >>> 1)) ? 31'(ami2d_pkg::WMAX)
                                                     : 31'(root_r << 1);
    end else begin
      len_c = (root_r > 64'(ami2d_pkg::WMAX)) ? 31'(ami2d_pkg::WMAX) : 31'(root_r);
    end
    spd_c = (len_c < min_speed_r) ? min_speed_r : len_c;
    if (spd_c > max_speed_r) begin
      spd_c = max_speed_r;
    end
  end

  assign wsize   = sel_r ? world_h_r : world_w_r;
  assign pos_sel = sel_r ? pos_y_r : pos_x_r;
  assign m_sel   = mag32(sel_r ? vy_r : vx_r);
  assign dvs     = (state_r == S_DIV) ? {2'b00, len_r} : {2'b00, wsize};
  assign rem2    = (state_r == S_DIV) ? {rem_r[31:0], 1'b0} : {rem_r[31:0], dvd_r[31]};
  assign rem_ge  = rem2 >= dvs;
  assign rem_sub = rem_ge ? (rem2 - dvs) : rem2;
  assign q_nxt   = {q_r[15:0], rem_ge};
  assign dir_new = (sel_r ? vy_r[31] : vx_r[31]) ? 32'(-{15'd0, q_nxt}) : {15'd0, q_nxt};
  assign pos_new = (pos_sel[31] && rem_sub != '0) ? 32'({2'b00, wsize} - rem_sub)
                                                   : rem_sub[31:0];

  always_comb begin
    if ({1'b0, m_sel} >= {2'b00, len_r}) begin
      rem_init = {1'b0, m_sel} - {2'b00, len_r};
    end else begin
      rem_init = {1'b0, m_sel};
    end
    if (rem_init >= {2'b00, len_r}) begin
      rem_init = {2'b00, len_r} - 33'd1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_WB;
      S_WB:   state_nxt = (pc_r == ami2d_pkg::UCODE_LAST) ? S_SQA : S_EXEC;
      S_SQA:  state_nxt = S_SQB;
      S_SQB:  state_nxt = S_ROOT;
      S_ROOT: if (cnt_r == 5'd31) state_nxt = S_LEN;
      S_LEN:  state_nxt = (len_c == '0) ? S_MODI : S_DIVI;
      S_DIVI: state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 5'd15) state_nxt = sel_r ? S_MODI : S_DIVI;
      S_MODI: begin
        if (wsize == '0) begin
          state_nxt = sel_r ? S_DONE : S_MODI;
        end else begin
          state_nxt = S_MOD;
        end
      end
      S_MOD:  if (cnt_r == 5'd31) state_nxt = sel_r ? S_DONE : S_MODI;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      pc_r         <= '0;
      cnt_r        <= '0;
      sel_r        <= 1'b0;
      time_step_r  <= ami2d_pkg::RST_TIME_STEP;
      speed_gain_r <= ami2d_pkg::RST_SPEED_GAIN;
      inv_mass_r   <= ami2d_pkg::RST_INV_MASS;
      cruise_r     <= ami2d_pkg::RST_CRUISE;
      min_speed_r  <= ami2d_pkg::RST_MIN_SPEED;
      max_speed_r  <= ami2d_pkg::RST_MAX_SPEED;
      world_w_r    <= ami2d_pkg::RST_WORLD_W;
      world_h_r    <= ami2d_pkg::RST_WORLD_H;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      dir_x_r      <= ami2d_pkg::ONE;
      dir_y_r      <= '0;
      cs_r         <= {1'b0, ami2d_pkg::RST_CRUISE};
      acc_x_r      <= '0;
      acc_y_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          ami2d_pkg::REG_TIME_STEP:  time_step_r  <= cfg_data;
          ami2d_pkg::REG_SPEED_GAIN: speed_gain_r <= cfg_data;
          ami2d_pkg::REG_INV_MASS:   inv_mass_r   <= cfg_data;
          ami2d_pkg::REG_CRUISE:     cruise_r     <= cfg_data;
          ami2d_pkg::REG_MIN_SPEED:  min_speed_r  <= cfg_data;
          ami2d_pkg::REG_MAX_SPEED:  max_speed_r  <= cfg_data;
          ami2d_pkg::REG_WORLD_W:    world_w_r    <= cfg_data;
          ami2d_pkg::REG_WORLD_H:    world_h_r    <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_DONE && state_nxt == S_IDLE) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          pc_r  <= '0;
          sel_r <= 1'b0;
        end
        S_WB: begin
          pc_r  <= pc_r + 5'd1;
          cnt_r <= '0;
          case (uop.dst)
            ami2d_pkg::DST_POSX: pos_x_r <= wb_res;
            ami2d_pkg::DST_POSY: pos_y_r <= wb_res;
            ami2d_pkg::DST_ACCX: acc_x_r <= wb_res;
            ami2d_pkg::DST_ACCY: acc_y_r <= wb_res;
            default: ;
          endcase
        end
        S_ROOT: cnt_r <= cnt_r + 5'd1;
        S_LEN: begin
          cs_r  <= {1'b0, spd_c};
          sel_r <= 1'b0;
        end
        S_DIVI: cnt_r <= '0;
        S_DIV: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) begin
            if (sel_r) dir_y_r <= dir_new;
            else dir_x_r <= dir_new;
            sel_r <= ~sel_r;
          end
        end
        S_MODI: begin
          cnt_r <= '0;
          if (wsize == '0) begin
            if (sel_r) pos_y_r <= '0;
            else pos_x_r <= '0;
            sel_r <= ~sel_r;
          end
        end
        S_MOD: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            if (sel_r) pos_y_r <= pos_new;
            else pos_x_r <= pos_new;
            sel_r <= ~sel_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      sf_r <= in_steer_forward;
      sl_r <= in_steer_lateral;
      ex_r <= in_external_force_x;
      ey_r <= in_external_force_y;
    end
    if (state_r == S_EXEC) begin
      prod_r <= prod;
      acc_r  <= sum33;
      neg_r  <= op_a[31] ^ op_b[31];
    end
    if (state_r == S_WB) begin
      case (uop.dst)
        ami2d_pkg::DST_T0: t0_r <= wb_res;
        ami2d_pkg::DST_T1: t1_r <= wb_res;
        ami2d_pkg::DST_FX: fx_r <= wb_res;
        ami2d_pkg::DST_FY: fy_r <= wb_res;
        ami2d_pkg::DST_VX: vx_r <= wb_res;
        ami2d_pkg::DST_VY: vy_r <= wb_res;
        default: ;
      endcase
    end
    if (state_r == S_SQA) begin
      n_r     <= prod;
      shift_r <= ax[31] | ay[31];
      root_r  <= '0;
      bit_r   <= 64'd1 << 62;
    end
    if (state_r == S_SQB) begin
      n_r <= n_r + prod;
    end
    if (state_r == S_ROOT) begin
      if (n_r >= rsum) begin
        n_r    <= n_r - rsum;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (state_r == S_LEN) begin
      len_r <= len_c;
    end
    if (state_r == S_DIVI) begin
      rem_r <= rem_init;
      q_r   <= {16'd0, ({1'b0, m_sel} >= {2'b00, len_r})};
    end
    if (state_r == S_DIV) begin
      rem_r <= rem_sub;
      q_r   <= q_nxt;
    end
    if (state_r == S_MODI) begin
      rem_r <= '0;
      dvd_r <= mag32(pos_sel);
    end
    if (state_r == S_MOD) begin
      rem_r <= rem_sub;
      dvd_r <= {dvd_r[30:0], 1'b0};
    end
    if (state_r == S_DONE && state_nxt == S_IDLE) begin
      out_px_r  <= pos_x_r[30:0];
      out_py_r  <= pos_y_r[30:0];
      out_hx_r  <= dir_x_r[17:0];
      out_hy_r  <= dir_y_r[17:0];
      out_spd_r <= cs_r[30:0];
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_position_x = out_px_r;
  assign out_position_y = out_py_r;
  assign out_heading_x  = out_hx_r;
  assign out_heading_y  = out_hy_r;
  assign out_speed_out  = out_spd_r;

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished step");

  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (world_w_r == '0 || out_px_r < world_w_r))
    else $error("wrapped x position outside the world");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r < 5'd16)
    else $error("heading divider ran past its last iteration");

endmodule

`default_nettype wire
